[rtl/core/pst_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the peer session table
// no dependencies; compile first

package pst_pkg;

	// default table depth
	localparam int PST_SLOTS = 8;

	// payload widths fixed by the request and response formats
	localparam int REQ_W    = 2;
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int TIME_W   = 32;
	localparam int IDXO_W   = 3;
	localparam int MASKO_W  = 8;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TOUCH  = 2'd0,
		REQ_EXPIRE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NONE   = 2'd3
	} pst_req_e;

	// controller to datapath commands
	typedef struct packed {
		logic start;   // latch request, restart sweep
		logic step;    // visit the current slot
		logic commit;  // write table, load response
	} pst_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last;    // current slot is the final one
	} pst_status_t;

endpackage

[rtl/core/pst_if.sv]
`timescale 1ns / 1ps
// request and response channel interfaces for the peer session table
// depends on pst_pkg for payload widths

interface pst_req_if;
	logic                          valid;
	logic                          ready;
	logic [pst_pkg::REQ_W-1:0]     req_type;
	logic [pst_pkg::ADDR_W-1:0]    peer_addr;
	logic [pst_pkg::PORT_W-1:0]    peer_port;
	logic [pst_pkg::TIME_W-1:0]    now_ms;

	modport source (output valid, req_type, peer_addr, peer_port, now_ms, input ready);
	modport sink   (input valid, req_type, peer_addr, peer_port, now_ms, output ready);
endinterface

interface pst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pst_pkg::IDXO_W-1:0]    slot_index;
	logic                          found;
	logic                          evicted;
	logic [pst_pkg::MASKO_W-1:0]   freed_mask;

	modport source (output valid, slot_index, found, evicted, freed_mask, input ready);
	modport sink   (input valid, slot_index, found, evicted, freed_mask, output ready);
endinterface

[rtl/core/peer_session_table_lru_core.sv]
`timescale 1ns / 1ps
// peer session table with least-recently-seen eviction, top level
// depends on pst_pkg, pst_if, pst_ctrl and pst_dpath
//
//  channel  | kind        | handshake             | payload
//  ---------+-------------+-----------------------+-----------------------------------------
//  req      | in, stream  | valid/ready           | req_type, peer_addr, peer_port, now_ms
//  rsp      | out, stream | valid/ready           | slot_index, found, evicted, freed_mask
//  cfg      | in, write   | cfg_wr_en, no wait    | cfg_wr_data -> idle_limit_ms
//
// each request is handled in order: the beat is accepted, the table is swept
// slot by slot, and a commit writes the table and loads the response.
// the sweep reads one slot a cycle, and no new beat is taken before the commit.
// a response waiting on rsp does not block the next request beat; only the
// commit waits for the response register to free up.
// reset clears all valid bits and the idle limit at once; no clearing pass.

module peer_session_table_lru_core #(
	parameter int SLOTS = pst_pkg::PST_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pst_req_if.sink                    req,
	pst_rsp_if.source                  rsp,
	input  logic                       cfg_wr_en,
	input  logic [pst_pkg::TIME_W-1:0] cfg_wr_data
);
	import pst_pkg::*;

	pst_cmd_t    cmd;
	pst_status_t status;

	logic              in_ready;
	logic              out_valid;
	logic [IDXO_W-1:0] slot_index;
	logic              found;
	logic              evicted;
	logic [MASKO_W-1:0] freed_mask;

	// sequencer
	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// table and response datapath
	pst_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req.req_type),
		.peer_addr   (req.peer_addr),
		.peer_port   (req.peer_port),
		.now_ms      (req.now_ms),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.slot_index  (slot_index),
		.found       (found),
		.evicted     (evicted),
		.freed_mask  (freed_mask)
	);

	// channel hookup
	assign req.ready      = in_ready;
	assign rsp.valid      = out_valid;
	assign rsp.slot_index = slot_index;
	assign rsp.found      = found;
	assign rsp.evicted    = evicted;
	assign rsp.freed_mask = freed_mask;

endmodule

[rtl/core/pst_ctrl.sv]
`timescale 1ns / 1ps
// request sequencer: accept, slot sweep, commit
// depends on pst_pkg for command and status structs

module pst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pst_pkg::pst_cmd_t    cmd,
	input  pst_pkg::pst_status_t status
);
	import pst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// commands decoded from state
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.start  = (state_q == ST_IDLE) && in_valid;
		cmd.step   = (state_q == ST_SWEEP);
		cmd.commit = (state_q == ST_APPLY) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (status.last) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// accepted beat starts a sweep
	a_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SWEEP)
		else $error("sweep did not start after request beat");

	// final slot leads to commit
	a_last_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.last |=> state_q == ST_APPLY)
		else $error("sweep end did not reach commit");

	// commit never overwrites an untaken response
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("response overwritten before taken");

endmodule

[rtl/core/pst_dpath.sv]
`timescale 1ns / 1ps
// session table storage, per-slot sweep trackers and response registers
// depends on pst_pkg for widths, request codes and command structs

module pst_dpath #(
	parameter int SLOTS = pst_pkg::PST_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pst_pkg::REQ_W-1:0]     req_type,
	input  logic [pst_pkg::ADDR_W-1:0]    peer_addr,
	input  logic [pst_pkg::PORT_W-1:0]    peer_port,
	input  logic [pst_pkg::TIME_W-1:0]    now_ms,
	input  logic                          cfg_wr_en,
	input  logic [pst_pkg::TIME_W-1:0]    cfg_wr_data,
	input  pst_pkg::pst_cmd_t             cmd,
	output pst_pkg::pst_status_t          status,
	output logic [pst_pkg::IDXO_W-1:0]    slot_index,
	output logic                          found,
	output logic                          evicted,
	output logic [pst_pkg::MASKO_W-1:0]   freed_mask
);
	import pst_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// table
	logic [SLOTS-1:0]  valid_q;
	logic [ADDR_W-1:0] addr_q  [SLOTS];
	logic [PORT_W-1:0] port_q  [SLOTS];
	logic [TIME_W-1:0] stamp_q [SLOTS];

	logic [TIME_W-1:0] idle_limit_q;

	// latched request
	pst_req_e          req_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [PORT_W-1:0] req_port_q;
	logic [TIME_W-1:0] now_q;

	// sweep trackers
	logic [IDX_W-1:0]  cnt_q;
	logic              match_hit_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [TIME_W-1:0] old_stamp_q;
	logic [SLOTS-1:0]  freed_q;

	// response registers
	logic [IDXO_W-1:0]  res_idx_q;
	logic               res_found_q;
	logic               res_evict_q;
	logic [MASKO_W-1:0] res_freed_q;

	// current slot view
	logic              vis_valid;
	logic [TIME_W-1:0] vis_stamp;
	logic              vis_hit;
	logic [TIME_W-1:0] age_diff;
	logic [TIME_W-1:0] elapsed;
	logic              vis_expire;

	// commit selection
	logic [IDX_W-1:0]   sel_idx;
	logic               sel_evict;
	logic [IDXO_W-1:0]  sel_idx3;
	logic [IDXO_W-1:0]  match_idx3;
	logic [MASKO_W-1:0] freed8;

	assign status.last = (cnt_q == IDX_W'(SLOTS - 1));

	always_comb begin
		vis_valid  = valid_q[cnt_q];
		vis_stamp  = stamp_q[cnt_q];
		vis_hit    = vis_valid && (addr_q[cnt_q] == req_addr_q)
		             && (port_q[cnt_q] == req_port_q);
		age_diff   = vis_stamp - old_stamp_q;
		elapsed    = now_q - vis_stamp;
		vis_expire = (req_q == REQ_EXPIRE) && vis_valid && (elapsed > idle_limit_q);
	end

	// touch target: match, else lowest free, else oldest
	always_comb begin
		sel_evict = !match_hit_q && !free_hit_q;
		if (match_hit_q) sel_idx = match_idx_q;
		else if (free_hit_q) sel_idx = free_idx_q;
		else sel_idx = old_idx_q;
	end

	// fit slot index and freed mask to response widths
	generate
		if (IDX_W >= IDXO_W) begin : g_idx_trunc
			assign sel_idx3   = sel_idx[IDXO_W-1:0];
			assign match_idx3 = match_idx_q[IDXO_W-1:0];
		end else begin : g_idx_ext
			assign sel_idx3   = {{(IDXO_W-IDX_W){1'b0}}, sel_idx};
			assign match_idx3 = {{(IDXO_W-IDX_W){1'b0}}, match_idx_q};
		end
		if (SLOTS >= MASKO_W) begin : g_mask_trunc
			assign freed8 = freed_q[MASKO_W-1:0];
		end else begin : g_mask_ext
			assign freed8 = {{(MASKO_W-SLOTS){1'b0}}, freed_q};
		end
	endgenerate

	// idle limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= '0;
		end else if (cfg_wr_en) begin
			idle_limit_q <= cfg_wr_data;
		end
	end

	// valid bits: cleared by expiry, set by allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.step && vis_expire) valid_q[cnt_q] <= 1'b0;
			if (cmd.commit && req_q == REQ_TOUCH && !match_hit_q) valid_q[sel_idx] <= 1'b1;
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		if (cmd.commit && req_q == REQ_TOUCH) begin
			stamp_q[sel_idx] <= now_q;
			if (!match_hit_q) begin
				addr_q[sel_idx] <= req_addr_q;
				port_q[sel_idx] <= req_port_q;
			end
		end
	end

	// request latch and sweep trackers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q       <= pst_req_e'(req_type);
			req_addr_q  <= peer_addr;
			req_port_q  <= peer_port;
			now_q       <= now_ms;
			cnt_q       <= '0;
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
			freed_q     <= '0;
		end else if (cmd.step) begin
			if (!status.last) cnt_q <= cnt_q + 1'b1;
			if (vis_hit && !match_hit_q) begin
				match_hit_q <= 1'b1;
				match_idx_q <= cnt_q;
			end
			if (!vis_valid && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= cnt_q;
			end
			// wrap-aware oldest: newer candidate wins only on negative difference
			if (cnt_q == '0 || age_diff[TIME_W-1]) begin
				old_idx_q   <= cnt_q;
				old_stamp_q <= vis_stamp;
			end
			if (vis_expire) freed_q[cnt_q] <= 1'b1;
		end
	end

	// response load
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (req_q)
				REQ_TOUCH: begin
					res_idx_q   <= sel_idx3;
					res_found_q <= match_hit_q;
					res_evict_q <= sel_evict;
					res_freed_q <= '0;
				end
				REQ_EXPIRE: begin
					res_idx_q   <= '0;
					res_found_q <= 1'b0;
					res_evict_q <= 1'b0;
					res_freed_q <= freed8;
				end
				REQ_LOOKUP: begin
					res_idx_q   <= match_hit_q ? match_idx3 : '0;
					res_found_q <= match_hit_q;
					res_evict_q <= 1'b0;
					res_freed_q <= '0;
				end
				default: begin
					res_idx_q   <= '0;
					res_found_q <= 1'b0;
					res_evict_q <= 1'b0;
					res_freed_q <= '0;
				end
			endcase
		end
	end

	assign slot_index = res_idx_q;
	assign found      = res_found_q;
	assign evicted    = res_evict_q;
	assign freed_mask = res_freed_q;

	// freed slots are already invalid when the response is built
	a_freed_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (freed_q & valid_q) == '0)
		else $error("freed slot still valid at commit");

	// a touch always leaves a live session
	a_touch_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && req_q == REQ_TOUCH |=> valid_q != '0)
		else $error("touch left table empty");

	// sweep counter stays inside the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q <= IDX_W'(SLOTS - 1))
		else $error("sweep index out of range");

endmodule

[tb/pst_session_checker.sv]
`timescale 1ns / 1ps
// request/response checker for the peer session table: mirrors the table and compares beats
// depends on pst_pkg and pst_if

module pst_session_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	pst_req_if                         req,
	pst_rsp_if                         rsp,
	input  logic                       cfg_wr_en,
	input  logic [pst_pkg::TIME_W-1:0] cfg_wr_data,
	output int unsigned                fail_count,
	output int unsigned                pending
);
	import pst_pkg::*;

	localparam int SLOTS = PST_SLOTS;

	typedef struct packed {
		logic [IDXO_W-1:0]  slot_index;
		logic               found;
		logic               evicted;
		logic [MASKO_W-1:0] freed_mask;
	} session_rsp_t;

	// mirrored session table and idle limit
	logic              sess_valid [SLOTS];
	logic [ADDR_W-1:0] sess_addr  [SLOTS];
	logic [PORT_W-1:0] sess_port  [SLOTS];
	logic [TIME_W-1:0] sess_stamp [SLOTS];
	logic [TIME_W-1:0] idle_limit;

	// responses still owed by the block, oldest first
	session_rsp_t owed_rsp_q [$];

	function automatic int find_session(input logic [ADDR_W-1:0] addr,
			input logic [PORT_W-1:0] port);
		for (int i = 0; i < SLOTS; i++) begin
			if (sess_valid[i] && sess_addr[i] == addr && sess_port[i] == port)
				return i;
		end
		return -1;
	endfunction

	// apply one request to the mirrored table and return the response it earns
	function automatic session_rsp_t serve_request(input pst_req_e kind,
			input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port,
			input logic [TIME_W-1:0] now);
		session_rsp_t r;
		int idx;
		logic [TIME_W-1:0] diff;
		r = '0;
		case (kind)
			REQ_TOUCH: begin
				idx = find_session(addr, port);
				if (idx >= 0) begin
					r.found = 1'b1;
				end else begin
					// lowest free slot first
					for (int i = 0; i < SLOTS; i++) begin
						if (!sess_valid[i] && idx < 0)
							idx = i;
					end
					// table full: oldest stamp by wrapping signed difference, ties keep low index
					if (idx < 0) begin
						idx = 0;
						for (int i = 1; i < SLOTS; i++) begin
							diff = sess_stamp[i] - sess_stamp[idx];
							if (diff[TIME_W-1])
								idx = i;
						end
						r.evicted = 1'b1;
					end
					sess_valid[idx] = 1'b1;
					sess_addr[idx]  = addr;
					sess_port[idx]  = port;
				end
				sess_stamp[idx] = now;
				r.slot_index = idx[IDXO_W-1:0];
			end
			REQ_EXPIRE: begin
				for (int i = 0; i < SLOTS; i++) begin
					diff = now - sess_stamp[i];
					if (sess_valid[i] && diff > idle_limit) begin
						sess_valid[i] = 1'b0;
						if (i < MASKO_W)
							r.freed_mask[i] = 1'b1;
					end
				end
			end
			REQ_LOOKUP: begin
				idx = find_session(addr, port);
				if (idx >= 0) begin
					r.found = 1'b1;
					r.slot_index = idx[IDXO_W-1:0];
				end
			end
			default: begin
				// unused code: table untouched, all-zero response
			end
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// watch both channels and the limit register
	always @(posedge clk or negedge arst_n) begin
		session_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				sess_valid[i] = 1'b0;
				sess_addr[i]  = '0;
				sess_port[i]  = '0;
				sess_stamp[i] = '0;
			end
			idle_limit = '0;
			owed_rsp_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// response beat against the oldest owed response
			if (rsp.valid && rsp.ready) begin
				if (owed_rsp_q.size() == 0) begin
					$display("%0t: unexpected response beat: expected none, actual %0h/%0b/%0b/%0h",
						$time, rsp.slot_index, rsp.found, rsp.evicted, rsp.freed_mask);
					fail_count++;
				end else begin
					want = owed_rsp_q.pop_front();
					compare_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
					compare_field("found", 32'(want.found), 32'(rsp.found));
					compare_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
					compare_field("freed_mask", 32'(want.freed_mask), 32'(rsp.freed_mask));
				end
			end
			// request beat updates the mirror
			if (req.valid && req.ready)
				owed_rsp_q.push_back(serve_request(pst_req_e'(req.req_type), req.peer_addr,
					req.peer_port, req.now_ms));
			if (cfg_wr_en)
				idle_limit = cfg_wr_data;
			pending = owed_rsp_q.size();
		end
	end

endmodule

[tb/peer_session_table_lru_core_tb.sv]
`timescale 1ns / 1ps
// testbench top for the peer session table: clock, reset, request and stall stimulus, verdict
// depends on pst_pkg, pst_if, the core and pst_session_checker

module peer_session_table_lru_core_tb;
	import pst_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = PST_SLOTS + 6;
	localparam int PHASES        = 6;
	localparam int PHASE_BEATS   = 272;
	localparam int POOL_N        = 12;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [TIME_W-1:0] cfg_wr_data;
	int unsigned       fail_count;
	int unsigned       pending;

	bit          quiet = 1'b0;
	int unsigned idle_pct = 20;
	int unsigned rsp_stall_left = 0;
	int unsigned stuck_cycles = 0;

	// peers reused so that sessions match, fill the table and get evicted
	logic [ADDR_W-1:0] pool_addr [POOL_N];
	logic [PORT_W-1:0] pool_port [POOL_N];
	logic [TIME_W-1:0] clock_ms;

	pst_req_if req_ch ();
	pst_rsp_if rsp_ch ();

	peer_session_table_lru_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	pst_session_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// response side back-pressure in bursts
	always @(posedge clk) begin
		if (rsp_stall_left != 0) begin
			rsp_stall_left <= rsp_stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			rsp_stall_left <= $urandom_range(0, 3);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// one request beat, with an optional sender gap in front of it
	task automatic send_beat(input pst_req_e kind, input logic [ADDR_W-1:0] addr,
			input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.peer_addr <= addr;
		req_ch.peer_port <= port;
		req_ch.now_ms    <= now;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// stop sending and let every owed response drain
	task automatic drain_idle();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [TIME_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic refresh_pool();
		for (int k = 0; k < POOL_N; k++) begin
			pool_addr[k] = $urandom;
			pool_port[k] = PORT_W'($urandom);
		end
		// near misses: same address other port, same port other address
		pool_addr[1] = pool_addr[0];
		pool_port[3] = pool_port[2];
	endtask

	// mostly pool peers on a creeping clock, with noise peers and time jumps
	task automatic random_beat();
		int unsigned pick;
		int unsigned sel;
		pst_req_e kind;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			kind = REQ_TOUCH;
		else if (pick < 78)
			kind = REQ_LOOKUP;
		else if (pick < 92)
			kind = REQ_EXPIRE;
		else
			kind = REQ_NONE;
		sel  = $urandom_range(0, POOL_N - 1);
		addr = pool_addr[sel];
		port = pool_port[sel];
		if ($urandom_range(0, 9) == 0) begin
			addr = $urandom;
			port = PORT_W'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 85)
			clock_ms += $urandom_range(0, 20);
		else if (pick < 95)
			clock_ms += $urandom_range(0, 400);
		else
			clock_ms += $urandom;
		send_beat(kind, addr, port, clock_ms);
	endtask

	initial begin
		logic [TIME_W-1:0] limits [PHASES];
		arst_n = 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_NONE;
		req_ch.peer_addr <= '0;
		req_ch.peer_port <= '0;
		req_ch.now_ms    <= '0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset idle limit of zero
		send_beat(REQ_LOOKUP, '0, '0, '0);                    // cleared entry must not match
		send_beat(REQ_EXPIRE, '0, '0, '0);                    // sweep of an empty table
		send_beat(REQ_TOUCH, '0, '0, '0);
		send_beat(REQ_TOUCH, '1, '1, '1);
		send_beat(REQ_TOUCH, 32'h0000_0001, 16'h0001, 32'h7FFF_FFFF);
		send_beat(REQ_TOUCH, 32'h8000_0000, 16'h8000, 32'h8000_0000);
		for (int k = 4; k < PST_SLOTS; k++)
			send_beat(REQ_TOUCH, 32'hC0A8_0000 + k, 16'd5000, 32'd5);  // equal stamps
		send_beat(REQ_TOUCH, 32'h0A00_0001, 16'd53, 32'd6);   // full table, evict
		send_beat(REQ_TOUCH, 32'h0A00_0001, 16'd53, 32'd7);   // refresh existing
		send_beat(REQ_TOUCH, 32'h0A00_0002, 16'd53, 32'd7);   // evict again among ties
		send_beat(REQ_LOOKUP, 32'h0A00_0001, 16'd53, '0);
		send_beat(REQ_LOOKUP, 32'h0000_0000, 16'h0001, '0);   // address hit, port miss
		send_beat(REQ_LOOKUP, '1, '1, '0);
		send_beat(REQ_NONE, '1, '1, '1);
		send_beat(REQ_TOUCH, 32'hC0A8_0005, 16'd5000, 32'd9);
		send_beat(REQ_EXPIRE, '1, '1, 32'd7);                 // zero limit frees all but stamp 7
		send_beat(REQ_LOOKUP, 32'h0A00_0001, 16'd53, '0);
		send_beat(REQ_TOUCH, 32'h0000_0002, 16'h0002, 32'd8); // reuse lowest free slot

		// random phases across idle limits, extremes included, last one without idling
		limits[0] = '1;
		limits[1] = 32'd1;
		limits[2] = 32'd60;
		limits[3] = $urandom;
		limits[4] = 32'd0;
		limits[5] = $urandom_range(20, 300);
		for (int p = 0; p < PHASES; p++) begin
			drain_idle();
			write_limit(limits[p]);
			refresh_pool();
			clock_ms = $urandom;
			idle_pct = (p == 2) ? 0 : 25;
			quiet = (p == PHASES - 1);
			repeat (PHASE_BEATS) random_beat();
		end

		drain_idle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
